// ===== rtl/lavm_pkg.sv =====
// shared constants and types for the look-at view matrix unit
package lavm_pkg;

   localparam int FRAC_BITS_DEF = 16;   // default fractional bits of the fixed-point format
   localparam int WORD_W        = 32;   // input coordinates and translation terms
   localparam int AXIS_W        = 18;   // axis component ports
   localparam int MAG_W         = 30;   // normalized magnitude, top bit at 2^29
   localparam int ROOT_W        = 31;   // floor sqrt of three squared magnitudes
   localparam int CHUNK_W       = 8;    // leading-one search granule

   typedef logic signed [WORD_W-1:0] word_type;

endpackage

// ===== rtl/look_at_view_matrix_unit.sv =====
// Right-handed look-at view matrix: takes eye, target and up in signed fixed point with
// FRAC_BITS fractional bits and returns the three camera axes and the translation terms.
// One item is accepted every clock cycle; busy is high only during reset. Each item's
// result appears on rsp_strobe exactly 2*FRAC_BITS+89 cycles after it is accepted (121 at
// the default of 16 fractional bits), in input order, and must be taken in that cycle.
// The latency comes from two normalizer pipelines in series, each with a 31-stage square
// root and a FRAC_BITS+1 stage divider, plus the cross and dot product stages.
module look_at_view_matrix_unit #(
   parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [lavm_pkg::WORD_W-1:0]    req_eye_x,
   input  logic signed [lavm_pkg::WORD_W-1:0]    req_eye_y,
   input  logic signed [lavm_pkg::WORD_W-1:0]    req_eye_z,
   input  logic signed [lavm_pkg::WORD_W-1:0]    req_target_x,
   input  logic signed [lavm_pkg::WORD_W-1:0]    req_target_y,
   input  logic signed [lavm_pkg::WORD_W-1:0]    req_target_z,
   input  logic signed [lavm_pkg::WORD_W-1:0]    req_up_x,
   input  logic signed [lavm_pkg::WORD_W-1:0]    req_up_y,
   input  logic signed [lavm_pkg::WORD_W-1:0]    req_up_z,
   output logic                                  rsp_strobe,
   output logic signed [lavm_pkg::AXIS_W-1:0]    rsp_right_x,
   output logic signed [lavm_pkg::AXIS_W-1:0]    rsp_right_y,
   output logic signed [lavm_pkg::AXIS_W-1:0]    rsp_right_z,
   output logic signed [lavm_pkg::AXIS_W-1:0]    rsp_upward_x,
   output logic signed [lavm_pkg::AXIS_W-1:0]    rsp_upward_y,
   output logic signed [lavm_pkg::AXIS_W-1:0]    rsp_upward_z,
   output logic signed [lavm_pkg::AXIS_W-1:0]    rsp_back_x,
   output logic signed [lavm_pkg::AXIS_W-1:0]    rsp_back_y,
   output logic signed [lavm_pkg::AXIS_W-1:0]    rsp_back_z,
   output logic signed [lavm_pkg::WORD_W-1:0]    rsp_shift_x,
   output logic signed [lavm_pkg::WORD_W-1:0]    rsp_shift_y,
   output logic signed [lavm_pkg::WORD_W-1:0]    rsp_shift_z
);

   localparam int WW   = lavm_pkg::WORD_W;
   localparam int OW   = lavm_pkg::AXIS_W;
   localparam int AW   = FRAC_BITS + 2;
   localparam int DFW  = WW + 1;
   localparam int SW1  = 6 * WW;
   localparam int PW1  = WW + AW;
   localparam int CW1  = WW + AW + 1;
   localparam int SW2  = 3 * WW + 3 * AW;
   localparam int PRW  = 2 * AW;
   localparam int UW   = 2 * AW + 1;
   localparam int UWX  = UW + 1;
   localparam int DW   = WW + AW + 2;
   localparam int DWX  = DW + 1;
   localparam int LAT  = 2 * FRAC_BITS + 89;
   localparam logic signed [AW-1:0] ONE_S = AW'(1) << FRAC_BITS;

   typedef logic signed [AW-1:0] axis_type;

   // round half away from zero to FRAC_BITS fractional bits, clamp to the unit range
   function automatic axis_type unit_of(input logic signed [UW-1:0] u);
      logic signed [UWX-1:0] ue;
      logic [UWX-1:0]        um;
      logic [UWX-1:0]        rm;
      ue = UWX'(u);
      um = u[UW-1] ? -ue : ue;
      rm = (um + (UWX'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (rm > (UWX'(1) << FRAC_BITS)) rm = UWX'(1) << FRAC_BITS;
      unit_of = u[UW-1] ? -AW'(rm) : AW'(rm);
   endfunction

   // negate, round half away from zero, saturate to the word range
   function automatic lavm_pkg::word_type shift_of(input logic signed [DW-1:0] d);
      logic signed [DWX-1:0] de;
      logic [DWX-1:0]        dm;
      logic [DWX-1:0]        rm;
      de = DWX'(d);
      dm = d[DW-1] ? -de : de;
      rm = (dm + (DWX'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (!d[DW-1] && (d != '0)) begin
         if (rm > DWX'(64'h8000_0000)) shift_of = 32'sh8000_0000;
         else shift_of = -WW'(rm);
      end else begin
         if (rm > DWX'(64'h7FFF_FFFF)) shift_of = 32'sh7FFF_FFFF;
         else shift_of = WW'(rm);
      end
   endfunction

   lavm_pkg::word_type req_eye [3];
   lavm_pkg::word_type req_tgt [3];
   lavm_pkg::word_type req_up  [3];

   assign req_eye = '{req_eye_x, req_eye_y, req_eye_z};
   assign req_tgt = '{req_target_x, req_target_y, req_target_z};
   assign req_up  = '{req_up_x, req_up_y, req_up_z};
   assign busy    = reset;

   // difference vector
   logic                   t1_valid_ff;
   lavm_pkg::word_type     t1_eye_ff [3];
   lavm_pkg::word_type     t1_up_ff  [3];
   logic signed [DFW-1:0]  t1_diff_ff [3];

   // back axis normalizer
   logic            n1_valid;
   axis_type        n1_back [3];
   logic [SW1-1:0]  n1_side;
   lavm_pkg::word_type n1_eye [3];
   lavm_pkg::word_type n1_up  [3];

   // up x back
   logic                  t2_valid_ff;
   lavm_pkg::word_type    t2_eye_ff  [3];
   axis_type              t2_back_ff [3];
   logic signed [PW1-1:0] t2_pr_ff [6];
   logic signed [PW1-1:0] t2_pr_in [6];
   logic                  t3_valid_ff;
   lavm_pkg::word_type    t3_eye_ff  [3];
   axis_type              t3_back_ff [3];
   logic signed [CW1-1:0] t3_cross_ff [3];

   // right axis normalizer
   logic            n2_valid;
   axis_type        n2_right [3];
   logic [SW2-1:0]  n2_side;
   lavm_pkg::word_type n2_eye  [3];
   axis_type        n2_back [3];

   // back x right and the first two dot products
   logic                  t4_valid_ff;
   lavm_pkg::word_type    t4_eye_ff   [3];
   axis_type              t4_back_ff  [3];
   axis_type              t4_right_ff [3];
   logic signed [PRW-1:0] t4_ur_ff [6];
   logic signed [PRW-1:0] t4_ur_in [6];
   logic signed [PW1-1:0] t4_dr_ff [3];
   logic signed [PW1-1:0] t4_db_ff [3];
   logic                  t5_valid_ff;
   lavm_pkg::word_type    t5_eye_ff   [3];
   axis_type              t5_back_ff  [3];
   axis_type              t5_right_ff [3];
   logic signed [UW-1:0]  t5_u_ff [3];
   logic signed [DW-1:0]  t5_sr_ff, t5_sb_ff;
   logic                  t6_valid_ff;
   lavm_pkg::word_type    t6_eye_ff    [3];
   axis_type              t6_back_ff   [3];
   axis_type              t6_right_ff  [3];
   axis_type              t6_upward_ff [3];
   lavm_pkg::word_type    t6_shr_ff, t6_shb_ff;
   logic                  t7_valid_ff;
   axis_type              t7_back_ff   [3];
   axis_type              t7_right_ff  [3];
   axis_type              t7_upward_ff [3];
   lavm_pkg::word_type    t7_shr_ff, t7_shb_ff;
   logic signed [PW1-1:0] t7_du_ff [3];
   logic                  t8_valid_ff;
   axis_type              t8_back_ff   [3];
   axis_type              t8_right_ff  [3];
   axis_type              t8_upward_ff [3];
   lavm_pkg::word_type    t8_shr_ff, t8_shb_ff;
   logic signed [DW-1:0]  t8_su_ff;

   // result registers
   logic                  o_valid_ff;
   axis_type              o_right_ff  [3];
   axis_type              o_upward_ff [3];
   axis_type              o_back_ff   [3];
   lavm_pkg::word_type    o_shift_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_valid_ff <= 1'b0;
         t4_valid_ff <= 1'b0;
         t5_valid_ff <= 1'b0;
         t6_valid_ff <= 1'b0;
         t7_valid_ff <= 1'b0;
         t8_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         t1_valid_ff <= start && !busy;
         t2_valid_ff <= n1_valid;
         t3_valid_ff <= t2_valid_ff;
         t4_valid_ff <= n2_valid;
         t5_valid_ff <= t4_valid_ff;
         t6_valid_ff <= t5_valid_ff;
         t7_valid_ff <= t6_valid_ff;
         t8_valid_ff <= t7_valid_ff;
         o_valid_ff  <= t8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         t1_eye_ff[j]  <= req_eye[j];
         t1_up_ff[j]   <= req_up[j];
         t1_diff_ff[j] <= DFW'(req_eye[j]) - DFW'(req_tgt[j]);
      end
   end

   lavm_norm #(
      .IW (DFW),
      .SW (SW1),
      .FB (FRAC_BITS)
   ) u_norm_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t1_valid_ff),
      .in_vec    (t1_diff_ff),
      .in_side   ({t1_eye_ff[0], t1_eye_ff[1], t1_eye_ff[2],
                   t1_up_ff[0], t1_up_ff[1], t1_up_ff[2]}),
      .out_valid (n1_valid),
      .out_axis  (n1_back),
      .out_side  (n1_side)
   );

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         n1_eye[j] = n1_side[SW1-1-WW*j -: WW];
         n1_up[j]  = n1_side[3*WW-1-WW*j -: WW];
      end
      t2_pr_in[0] = PW1'(n1_up[1]) * PW1'(n1_back[2]);
      t2_pr_in[1] = PW1'(n1_up[2]) * PW1'(n1_back[1]);
      t2_pr_in[2] = PW1'(n1_up[2]) * PW1'(n1_back[0]);
      t2_pr_in[3] = PW1'(n1_up[0]) * PW1'(n1_back[2]);
      t2_pr_in[4] = PW1'(n1_up[0]) * PW1'(n1_back[1]);
      t2_pr_in[5] = PW1'(n1_up[1]) * PW1'(n1_back[0]);
   end

   always_ff @(posedge clock) begin
      t2_eye_ff  <= n1_eye;
      t2_back_ff <= n1_back;
      t2_pr_ff   <= t2_pr_in;
      t3_eye_ff  <= t2_eye_ff;
      t3_back_ff <= t2_back_ff;
      for (int j = 0; j < 3; j++) begin
         t3_cross_ff[j] <= CW1'(t2_pr_ff[2*j]) - CW1'(t2_pr_ff[2*j+1]);
      end
   end

   lavm_norm #(
      .IW (CW1),
      .SW (SW2),
      .FB (FRAC_BITS)
   ) u_norm_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t3_valid_ff),
      .in_vec    (t3_cross_ff),
      .in_side   ({t3_eye_ff[0], t3_eye_ff[1], t3_eye_ff[2],
                   t3_back_ff[0], t3_back_ff[1], t3_back_ff[2]}),
      .out_valid (n2_valid),
      .out_axis  (n2_right),
      .out_side  (n2_side)
   );

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         n2_eye[j]  = n2_side[SW2-1-WW*j -: WW];
         n2_back[j] = n2_side[3*AW-1-AW*j -: AW];
      end
      t4_ur_in[0] = PRW'(n2_back[1]) * PRW'(n2_right[2]);
      t4_ur_in[1] = PRW'(n2_back[2]) * PRW'(n2_right[1]);
      t4_ur_in[2] = PRW'(n2_back[2]) * PRW'(n2_right[0]);
      t4_ur_in[3] = PRW'(n2_back[0]) * PRW'(n2_right[2]);
      t4_ur_in[4] = PRW'(n2_back[0]) * PRW'(n2_right[1]);
      t4_ur_in[5] = PRW'(n2_back[1]) * PRW'(n2_right[0]);
   end

   always_ff @(posedge clock) begin
      t4_eye_ff   <= n2_eye;
      t4_back_ff  <= n2_back;
      t4_right_ff <= n2_right;
      t4_ur_ff    <= t4_ur_in;
      for (int j = 0; j < 3; j++) begin
         t4_dr_ff[j] <= PW1'(n2_eye[j]) * PW1'(n2_right[j]);
         t4_db_ff[j] <= PW1'(n2_eye[j]) * PW1'(n2_back[j]);
      end

      t5_eye_ff   <= t4_eye_ff;
      t5_back_ff  <= t4_back_ff;
      t5_right_ff <= t4_right_ff;
      for (int j = 0; j < 3; j++) begin
         t5_u_ff[j] <= UW'(t4_ur_ff[2*j]) - UW'(t4_ur_ff[2*j+1]);
      end
      t5_sr_ff <= DW'(t4_dr_ff[0]) + DW'(t4_dr_ff[1]) + DW'(t4_dr_ff[2]);
      t5_sb_ff <= DW'(t4_db_ff[0]) + DW'(t4_db_ff[1]) + DW'(t4_db_ff[2]);

      t6_eye_ff   <= t5_eye_ff;
      t6_back_ff  <= t5_back_ff;
      t6_right_ff <= t5_right_ff;
      for (int j = 0; j < 3; j++) begin
         t6_upward_ff[j] <= unit_of(t5_u_ff[j]);
      end
      t6_shr_ff <= shift_of(t5_sr_ff);
      t6_shb_ff <= shift_of(t5_sb_ff);

      // eye dot upward needs the rounded upward axis
      t7_back_ff   <= t6_back_ff;
      t7_right_ff  <= t6_right_ff;
      t7_upward_ff <= t6_upward_ff;
      t7_shr_ff    <= t6_shr_ff;
      t7_shb_ff    <= t6_shb_ff;
      for (int j = 0; j < 3; j++) begin
         t7_du_ff[j] <= PW1'(t6_eye_ff[j]) * PW1'(t6_upward_ff[j]);
      end

      t8_back_ff   <= t7_back_ff;
      t8_right_ff  <= t7_right_ff;
      t8_upward_ff <= t7_upward_ff;
      t8_shr_ff    <= t7_shr_ff;
      t8_shb_ff    <= t7_shb_ff;
      t8_su_ff     <= DW'(t7_du_ff[0]) + DW'(t7_du_ff[1]) + DW'(t7_du_ff[2]);

      o_back_ff     <= t8_back_ff;
      o_right_ff    <= t8_right_ff;
      o_upward_ff   <= t8_upward_ff;
      o_shift_ff[0] <= t8_shr_ff;
      o_shift_ff[1] <= shift_of(t8_su_ff);
      o_shift_ff[2] <= t8_shb_ff;
   end

   assign rsp_strobe   = o_valid_ff;
   assign rsp_right_x  = OW'(o_right_ff[0]);
   assign rsp_right_y  = OW'(o_right_ff[1]);
   assign rsp_right_z  = OW'(o_right_ff[2]);
   assign rsp_upward_x = OW'(o_upward_ff[0]);
   assign rsp_upward_y = OW'(o_upward_ff[1]);
   assign rsp_upward_z = OW'(o_upward_ff[2]);
   assign rsp_back_x   = OW'(o_back_ff[0]);
   assign rsp_back_y   = OW'(o_back_ff[1]);
   assign rsp_back_z   = OW'(o_back_ff[2]);
   assign rsp_shift_x  = o_shift_ff[0];
   assign rsp_shift_y  = o_shift_ff[1];
   assign rsp_shift_z  = o_shift_ff[2];

   logic upward_ok;
   logic back_zero;
   logic derived_zero;

   always_comb begin
      upward_ok    = 1'b1;
      back_zero    = 1'b1;
      derived_zero = 1'b1;
      for (int j = 0; j < 3; j++) begin
         if ((o_upward_ff[j] > ONE_S) || (o_upward_ff[j] < -ONE_S)) upward_ok = 1'b0;
         if (o_back_ff[j] != '0) back_zero = 1'b0;
         if ((o_right_ff[j] != '0) || (o_upward_ff[j] != '0)) derived_zero = 1'b0;
      end
   end

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without an item accepted at the pipeline depth");

   a_upward_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> upward_ok)
      else $error("upward axis outside the unit range");

   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && back_zero) |-> derived_zero)
      else $error("zero back axis gave nonzero right or upward axis");

endmodule

// ===== rtl/lavm_norm.sv =====
// pipelined 3-vector normalizer: shift to a fixed range, bit-serial sqrt stages, divide stages
module lavm_norm #(
   parameter int IW = lavm_pkg::WORD_W + 1,
   parameter int SW = lavm_pkg::WORD_W,
   parameter int FB = lavm_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [IW-1:0] in_vec [3],
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic signed [FB+1:0] out_axis [3],
   output logic [SW-1:0]        out_side
);

   localparam int AW  = FB + 2;
   localparam int MW  = lavm_pkg::MAG_W;
   localparam int TOP = MW - 1;
   localparam int SQW = 2 * MW + 2;
   localparam int RW  = lavm_pkg::ROOT_W;
   localparam int NSQ = RW;
   localparam int NW  = RW + FB;
   localparam int QW  = FB + 1;
   localparam int CW  = lavm_pkg::CHUNK_W;
   localparam int NC  = (IW + CW - 1) / CW;
   localparam int LW  = $clog2(CW);
   localparam int PW  = $clog2(IW);
   localparam int NDV = FB + 1;
   localparam int DL  = FB + 40;
   localparam int DW  = SW + 4;
   localparam logic signed [AW-1:0] ONE_S = AW'(1) << FB;

   // control and sideband delay line, entry 0 is the first stage
   logic          dl_valid_ff [DL];
   logic          dl_valid_in [DL];
   logic [DW-1:0] dl_data_ff  [DL];
   logic [DW-1:0] dl_data_in  [DL];

   logic [IW-1:0] a_m_ff  [3];
   logic [NC-1:0] b1_nz_ff, b1_nz_in;
   logic [LW-1:0] b1_lp_ff [NC];
   logic [LW-1:0] b1_lp_in [NC];
   logic [IW-1:0] b1_m_ff [3];
   logic [PW-1:0] b2_pos_ff, b2_pos_in;
   logic [IW-1:0] b2_m_ff [3];
   logic [MW-1:0] c_m_ff  [3];
   logic [MW-1:0] c_m_in  [3];
   logic [2*MW-1:0] d_sq_ff [3];
   logic [MW-1:0] d_m_ff  [3];

   logic [SQW-1:0] sq_n_ff    [NSQ+1];
   logic [SQW-1:0] sq_n_in    [NSQ+1];
   logic [SQW-1:0] sq_root_ff [NSQ+1];
   logic [SQW-1:0] sq_root_in [NSQ+1];
   logic [MW-1:0]  sq_m_ff    [NSQ+1][3];
   logic [MW-1:0]  sq_m_in    [NSQ+1][3];

   logic [NW-1:0] dv_rem_ff [NDV+1][3];
   logic [NW-1:0] dv_rem_in [NDV+1][3];
   logic [QW-1:0] dv_q_ff   [NDV+1][3];
   logic [QW-1:0] dv_q_in   [NDV+1][3];
   logic [RW-1:0] dv_len_ff [NDV+1];
   logic [RW-1:0] dv_len_in [NDV+1];

   logic signed [AW-1:0] s_axis_ff [3];
   logic signed [AW-1:0] s_axis_in [3];

   // delay line
   always_comb begin
      dl_valid_in[0] = in_valid;
      dl_data_in[0]  = {in_side, (in_vec[0] == '0) && (in_vec[1] == '0) && (in_vec[2] == '0),
                        in_vec[2][IW-1], in_vec[1][IW-1], in_vec[0][IW-1]};
      for (int k = 1; k < DL; k++) begin
         dl_valid_in[k] = dl_valid_ff[k-1];
         dl_data_in[k]  = dl_data_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DL; k++) dl_valid_ff[k] <= 1'b0;
      end else begin
         dl_valid_ff <= dl_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_data_ff <= dl_data_in;
   end

   // leading-one search over the OR of the magnitudes, per chunk then across chunks
   always_comb begin
      logic [NC*CW-1:0] or_w;
      logic [CW-1:0]    chunk;
      or_w = (NC*CW)'(a_m_ff[0] | a_m_ff[1] | a_m_ff[2]);
      for (int c = 0; c < NC; c++) begin
         chunk = or_w[c*CW +: CW];
         b1_nz_in[c] = |chunk;
         b1_lp_in[c] = '0;
         for (int b = 0; b < CW; b++) begin
            if (chunk[b]) b1_lp_in[c] = LW'(b);
         end
      end
   end

   always_comb begin
      b2_pos_in = '0;
      for (int c = 0; c < NC; c++) begin
         if (b1_nz_ff[c]) b2_pos_in = PW'(c * CW) + PW'(b1_lp_ff[c]);
      end
   end

   // common shift puts the largest magnitude in [2^29, 2^30)
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (b2_pos_ff >= PW'(TOP)) begin
            c_m_in[j] = MW'(b2_m_ff[j] >> (b2_pos_ff - PW'(TOP)));
         end else begin
            c_m_in[j] = MW'(b2_m_ff[j] << (PW'(TOP) - b2_pos_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         a_m_ff[j]  <= in_vec[j][IW-1] ? $unsigned(-in_vec[j]) : $unsigned(in_vec[j]);
         b1_m_ff[j] <= a_m_ff[j];
         b2_m_ff[j] <= b1_m_ff[j];
         c_m_ff[j]  <= c_m_in[j];
         d_sq_ff[j] <= c_m_ff[j] * c_m_ff[j];
         d_m_ff[j]  <= c_m_ff[j];
      end
      b1_nz_ff  <= b1_nz_in;
      b1_lp_ff  <= b1_lp_in;
      b2_pos_ff <= b2_pos_in;
   end

   // square root, one result bit per stage
   always_comb begin
      logic [SQW-1:0] bit_v;
      logic [SQW-1:0] trial;
      sq_n_in[0]    = SQW'(d_sq_ff[0]) + SQW'(d_sq_ff[1]) + SQW'(d_sq_ff[2]);
      sq_root_in[0] = '0;
      sq_m_in[0]    = d_m_ff;
      for (int s = 1; s <= NSQ; s++) begin
         bit_v = SQW'(1) << (2 * (NSQ - s));
         trial = sq_root_ff[s-1] + bit_v;
         if (sq_n_ff[s-1] >= trial) begin
            sq_n_in[s]    = sq_n_ff[s-1] - trial;
            sq_root_in[s] = (sq_root_ff[s-1] >> 1) + bit_v;
         end else begin
            sq_n_in[s]    = sq_n_ff[s-1];
            sq_root_in[s] = sq_root_ff[s-1] >> 1;
         end
         sq_m_in[s] = sq_m_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      sq_n_ff    <= sq_n_in;
      sq_root_ff <= sq_root_in;
      sq_m_ff    <= sq_m_in;
   end

   // rounded restoring division, one quotient bit per stage
   always_comb begin
      logic [RW-1:0] len;
      logic [NW-1:0] cmp;
      len = RW'(sq_root_ff[NSQ]);
      dv_len_in[0] = len;
      for (int j = 0; j < 3; j++) begin
         dv_rem_in[0][j] = (NW'(sq_m_ff[NSQ][j]) << FB) + NW'(len >> 1);
         dv_q_in[0][j]   = '0;
      end
      for (int d = 1; d <= NDV; d++) begin
         cmp = NW'(dv_len_ff[d-1]) << (NDV - d);
         dv_len_in[d] = dv_len_ff[d-1];
         for (int j = 0; j < 3; j++) begin
            if (dv_rem_ff[d-1][j] >= cmp) begin
               dv_rem_in[d][j] = dv_rem_ff[d-1][j] - cmp;
               dv_q_in[d][j]   = dv_q_ff[d-1][j] | (QW'(1) << (NDV - d));
            end else begin
               dv_rem_in[d][j] = dv_rem_ff[d-1][j];
               dv_q_in[d][j]   = dv_q_ff[d-1][j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dv_rem_ff <= dv_rem_in;
      dv_q_ff   <= dv_q_in;
      dv_len_ff <= dv_len_in;
   end

   // clamp, sign, zero vector
   always_comb begin
      logic [QW-1:0] qc;
      logic [DW-1:0] ctl;
      ctl = dl_data_ff[DL-2];
      for (int j = 0; j < 3; j++) begin
         qc = dv_q_ff[NDV][j];
         if (qc > (QW'(1) << FB)) qc = QW'(1) << FB;
         if (ctl[3]) begin
            s_axis_in[j] = '0;
         end else if (ctl[j]) begin
            s_axis_in[j] = -AW'(qc);
         end else begin
            s_axis_in[j] = AW'(qc);
         end
      end
   end

   always_ff @(posedge clock) begin
      s_axis_ff <= s_axis_in;
   end

   assign out_valid = dl_valid_ff[DL-1];
   assign out_axis  = s_axis_ff;
   assign out_side  = dl_data_ff[DL-1][DW-1:4];

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_axis[0] <= ONE_S) && (out_axis[0] >= -ONE_S) &&
                    (out_axis[1] <= ONE_S) && (out_axis[1] >= -ONE_S) &&
                    (out_axis[2] <= ONE_S) && (out_axis[2] >= -ONE_S))
      else $error("normalized component out of unit range");

   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (out_valid && dl_data_ff[DL-1][3]) |->
         (out_axis[0] == '0) && (out_axis[1] == '0) && (out_axis[2] == '0))
      else $error("zero vector did not normalize to zero");

   a_sign_kept: assert property (@(posedge clock) disable iff (reset)
      out_valid |->
         (dl_data_ff[DL-1][0] ? (out_axis[0] <= 0) : (out_axis[0] >= 0)) &&
         (dl_data_ff[DL-1][1] ? (out_axis[1] <= 0) : (out_axis[1] >= 0)) &&
         (dl_data_ff[DL-1][2] ? (out_axis[2] <= 0) : (out_axis[2] >= 0)))
      else $error("normalized component lost the sign of its input");

endmodule
